// ===== hw/rtl/motif_mixture_forward_logsum_macros.svh =====
// Assertion macros for the motif mixture forward log-sum block.
// Used by the checker module; needs clk and rst in the enclosing scope.
`ifndef MOTIF_MIXTURE_FORWARD_LOGSUM_MACROS_SVH
`define MOTIF_MIXTURE_FORWARD_LOGSUM_MACROS_SVH

// Condition implies expression in the same cycle.
`define MMFL_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Condition implies expression in the next cycle.
`define MMFL_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hw/rtl/mmfl_pkg.sv =====
// Shared types, constants and score arithmetic for the forward log-sum block.
// No dependencies; imported by every module of the block but the checker.
package mmfl_pkg;

  localparam int SCORE_BITS = 32;
  localparam int MAX_MOTIFS = 4;
  localparam int MAX_WIDTH  = 32;
  localparam int HIST_AW    = $clog2(MAX_WIDTH);
  localparam int LANES      = MAX_MOTIFS + 1;
  localparam int CNT_BITS   = 6;

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic signed [SCORE_BITS+1:0] wide_t;
  typedef logic [13:0] diff_t;
  typedef logic [10:0] corr_t;

  localparam score_t NEG_INF = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam score_t POS_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam wide_t  NEG_W   = wide_t'(NEG_INF);
  localparam wide_t  POS_W   = wide_t'(POS_MAX);

  localparam logic [32:0] CORR_LIMIT = 33'd12288;
  localparam corr_t       CORR_ONE   = 11'd1024;

  // Register indexes (address bits 5:3)
  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_WIDTH0 = 3'd1;
  localparam logic [2:0] REG_WIDTH1 = 3'd2;
  localparam logic [2:0] REG_WIDTH2 = 3'd3;
  localparam logic [2:0] REG_WIDTH3 = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;
  localparam logic [2:0] REG_MPEN   = 3'd6;

  typedef struct packed {
    logic  start;
    diff_t diff;
  } lc_req_t;

  typedef struct packed {
    logic  done;
    corr_t corr;
  } lc_rsp_t;

  function automatic score_t clamp(wide_t s);
    score_t r;
    if (s <= NEG_W) r = NEG_INF;
    else if (s > POS_W) r = POS_MAX;
    else r = s[SCORE_BITS-1:0];
    return r;
  endfunction

  function automatic score_t in_score(logic [31:0] raw);
    score_t r;
    if (raw == 32'h8000_0000) r = NEG_INF;
    else r = clamp(wide_t'(signed'(raw)));
    return r;
  endfunction

  function automatic score_t pen_score(logic [15:0] raw);
    score_t r;
    if (raw == 16'h8000) r = NEG_INF;
    else r = score_t'(signed'(raw));
    return r;
  endfunction

  function automatic score_t add3(score_t a, score_t b, score_t c);
    score_t r;
    if (a == NEG_INF || b == NEG_INF || c == NEG_INF) r = NEG_INF;
    else r = clamp(wide_t'(a) + wide_t'(b) + wide_t'(c));
    return r;
  endfunction

  // 2^(-2^b/1024) in Q30
  function automatic logic [29:0] pow_tab(logic [3:0] b);
    logic [29:0] r;
    case (b)
      4'd0:    r = 30'd1073015252;
      4'd1:    r = 30'd1072289173;
      4'd2:    r = 30'd1070838486;
      4'd3:    r = 30'd1067942999;
      4'd4:    r = 30'd1062175491;
      4'd5:    r = 30'd1050733751;
      4'd6:    r = 30'd1028218693;
      4'd7:    r = 30'd984625594;
      4'd8:    r = 30'd902905651;
      4'd9:    r = 30'd759250125;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mmfl_lane.sv =====
// One path lane: forms history + emission + penalty for one term of the sum.
// Depends on mmfl_pkg.
module mmfl_lane import mmfl_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        enable,
  input  score_t      hist,
  input  logic [31:0] score,
  input  logic [15:0] pen,
  output score_t      term
);

  always_ff @(posedge clk) begin
    if (load) begin
      term <= enable ? add3(hist, in_score(score), pen_score(pen)) : NEG_INF;
    end
  end

endmodule

// ===== hw/rtl/mmfl_logcorr.sv =====
// Iterative log2(1 + 2^-d) correction unit over one shared 32x32 multiplier.
// Depends on mmfl_pkg; 10 power steps, one shift step, 11 squaring steps.
module mmfl_logcorr import mmfl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  lc_req_t req,
  output lc_rsp_t rsp
);

  typedef enum logic [1:0] {L_IDLE, L_POW, L_SHIFT, L_SQ} lstate_t;

  lstate_t     state;
  diff_t       diff;
  logic [3:0]  step;
  logic [30:0] y;
  logic [31:0] z;
  logic [10:0] v;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] zs;
  logic [11:0] v_inc;
  logic        done_r;

  always_comb begin
    if (state == L_POW) begin
      mul_a = {1'b0, y};
      mul_b = {2'b00, pow_tab(step)};
    end else begin
      mul_a = z;
      mul_b = z;
    end
    prod  = mul_a * mul_b;
    zs    = prod[61:30];
    v_inc = {1'b0, v} + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state)
        L_IDLE: begin
          if (req.start) begin
            diff  <= req.diff;
            y     <= 31'h4000_0000;
            step  <= 4'd0;
            state <= L_POW;
          end
        end
        L_POW: begin
          if (diff[step]) y <= prod[60:30];
          if (step == 4'd9) state <= L_SHIFT;
          else step <= step + 4'd1;
        end
        L_SHIFT: begin
          z     <= 32'h4000_0000 + {1'b0, y >> diff[13:10]};
          v     <= '0;
          step  <= 4'd0;
          state <= L_SQ;
        end
        L_SQ: begin
          // take one fraction bit of log2 per squaring
          v <= {v[9:0], zs[31]};
          z <= zs[31] ? {1'b0, zs[31:1]} : zs;
          if (step == 4'd10) begin
            done_r <= 1'b1;
            state  <= L_IDLE;
          end else begin
            step <= step + 4'd1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign rsp = {done_r, v_inc[11:1]};

endmodule

// ===== hw/rtl/mmfl_merge.sv =====
// Merging stage: folds the lane terms in order with a log2-sum.
// Depends on mmfl_pkg and mmfl_logcorr.
module mmfl_merge import mmfl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  score_t terms [LANES],
  output logic   done,
  output score_t acc
);

  typedef enum logic [1:0] {M_IDLE, M_STEP, M_WAIT} mstate_t;

  localparam int KB = $clog2(LANES + 1);

  mstate_t     state;
  logic [KB-1:0] k;
  score_t      hi;
  score_t      t_cur;
  score_t      hi_c;
  score_t      lo_c;
  logic [32:0] d_c;
  lc_req_t     lc_req;
  lc_rsp_t     lc_rsp;

  always_comb begin
    t_cur = NEG_INF;
    for (int i = 0; i < LANES; i++) begin
      if (k == KB'(i)) t_cur = terms[i];
    end
    hi_c = (acc > t_cur) ? acc : t_cur;
    lo_c = (acc > t_cur) ? t_cur : acc;
    d_c  = 33'(wide_t'(hi_c) - wide_t'(lo_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= M_IDLE;
      done         <= 1'b0;
      lc_req.start <= 1'b0;
    end else begin
      done         <= 1'b0;
      lc_req.start <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            acc   <= terms[0];
            k     <= KB'(1);
            state <= M_STEP;
          end
        end
        M_STEP: begin
          if (k == KB'(LANES)) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else if (acc == NEG_INF) begin
            acc <= t_cur;
            k   <= k + KB'(1);
          end else if (t_cur == NEG_INF) begin
            k <= k + KB'(1);
          end else if (d_c == 33'd0) begin
            acc <= clamp(wide_t'(hi_c) + wide_t'(CORR_ONE));
            k   <= k + KB'(1);
          end else if (d_c >= CORR_LIMIT) begin
            acc <= hi_c;
            k   <= k + KB'(1);
          end else begin
            hi           <= hi_c;
            lc_req.start <= 1'b1;
            lc_req.diff  <= d_c[13:0];
            state        <= M_WAIT;
          end
        end
        M_WAIT: begin
          if (lc_rsp.done) begin
            acc   <= clamp(wide_t'(hi) + wide_t'(lc_rsp.corr));
            k     <= k + KB'(1);
            state <= M_STEP;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  mmfl_logcorr u_logcorr (
    .clk (clk),
    .rst (rst),
    .req (lc_req),
    .rsp (lc_rsp)
  );

endmodule

// ===== hw/rtl/motif_mixture_forward_logsum.sv =====
// Top level of the motif mixture forward log-sum block.
// Depends on mmfl_pkg, mmfl_lane and mmfl_merge.
//
//   channel  | handshake                          | payload
//   ---------+------------------------------------+------------------------------
//   input    | in_valid / in_ready                | background_score, motif_score_0..3,
//            |                                    | end_of_sequence
//   output   | out_valid / out_ready              | prefix_score, is_total
//   config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// The log-adds of a transaction run one after another; each that needs the
// correction unit (up to four) goes through the shared multiplier, and a new
// transaction starts only when the previous result has been handed on.
// A new input is held in a one-deep buffer while the previous one is worked on,
// and a finished result waits in the output register while the next one runs.
// Reset is synchronous and restores the start-of-sequence state at once.
module motif_mixture_forward_logsum import mmfl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] background_score,
  input  logic [31:0] motif_score_0,
  input  logic [31:0] motif_score_1,
  input  logic [31:0] motif_score_2,
  input  logic [31:0] motif_score_3,
  input  logic        end_of_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] prefix_score,
  output logic        is_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {E_IDLE, E_READ, E_LANE, E_START, E_MERGE, E_DONE} estate_t;

  // configuration
  logic [2:0]  active_motifs;
  logic [5:0]  motif_width [MAX_MOTIFS];
  logic [15:0] base_penalty;
  logic [63:0] motif_penalties;

  // input buffer and working copy
  logic        buf_full;
  logic [31:0] buf_bg;
  logic [31:0] buf_ms [MAX_MOTIFS];
  logic        buf_eos;
  logic [31:0] w_bg;
  logic [31:0] w_ms [MAX_MOTIFS];
  logic        w_eos;

  // sequence state
  estate_t              state;
  logic [HIST_AW-1:0]   head;
  logic [CNT_BITS-1:0]  pos_count;
  logic                 zero_flag;
  score_t               prev;
  logic [2:0]           rcnt;
  score_t               hv [MAX_MOTIFS];

  // history memory
  score_t               hist_mem [MAX_WIDTH];
  logic [HIST_AW-1:0]   rd_addr;
  score_t               rd_data;
  logic                 rd_zero;
  logic                 mem_we;
  logic [HIST_AW-1:0]   wr_addr;

  logic [2:0]           n_act;
  logic                 fit [MAX_MOTIFS];
  logic [HIST_AW-1:0]   slot [MAX_MOTIFS];
  logic                 lane_load;
  logic                 merge_start;
  logic                 merge_done;
  score_t               merge_acc;
  score_t               terms [LANES];
  logic                 fire;
  logic                 cfg_wr;

  assign pready   = 1'b1;
  assign in_ready = !buf_full;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    case (paddr[5:3])
      REG_ACTIVE: prdata = {61'd0, active_motifs};
      REG_WIDTH0: prdata = {58'd0, motif_width[0]};
      REG_WIDTH1: prdata = {58'd0, motif_width[1]};
      REG_WIDTH2: prdata = {58'd0, motif_width[2]};
      REG_WIDTH3: prdata = {58'd0, motif_width[3]};
      REG_BASE:   prdata = {48'd0, base_penalty};
      REG_MPEN:   prdata = motif_penalties;
      default:    prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_motifs   <= 3'd1;
      for (int m = 0; m < MAX_MOTIFS; m++) motif_width[m] <= 6'd1;
      base_penalty    <= 16'd0;
      motif_penalties <= 64'h8000_8000_8000_8000;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        REG_ACTIVE: active_motifs   <= pwdata[2:0];
        REG_WIDTH0: motif_width[0]  <= pwdata[5:0];
        REG_WIDTH1: motif_width[1]  <= pwdata[5:0];
        REG_WIDTH2: motif_width[2]  <= pwdata[5:0];
        REG_WIDTH3: motif_width[3]  <= pwdata[5:0];
        REG_BASE:   base_penalty    <= pwdata[15:0];
        REG_MPEN:   motif_penalties <= pwdata;
        default:    ;
      endcase
    end
  end

  // which motif paths fit and where their history lies
  always_comb begin
    n_act = (active_motifs > 3'(MAX_MOTIFS)) ? 3'(MAX_MOTIFS) : active_motifs;
    for (int m = 0; m < MAX_MOTIFS; m++) begin
      fit[m]  = (3'(m) < n_act) && (motif_width[m] != 6'd0) &&
                (motif_width[m] <= 6'(MAX_WIDTH)) &&
                (pos_count >= motif_width[m] - 6'd1);
      slot[m] = head - HIST_AW'(motif_width[m] - 6'd1);
    end
    rd_addr = slot[rcnt[1:0]];
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[wr_addr] <= merge_acc;
    rd_data <= hist_mem[rd_addr];
    rd_zero <= zero_flag && (rd_addr == '0);
  end

  assign fire    = (state == E_DONE) && (!out_valid || out_ready);
  assign wr_addr = head + HIST_AW'(1);
  assign mem_we  = fire && !w_eos;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_bg    <= background_score;
      buf_ms[0] <= motif_score_0;
      buf_ms[1] <= motif_score_1;
      buf_ms[2] <= motif_score_2;
      buf_ms[3] <= motif_score_3;
      buf_eos   <= end_of_sequence;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= E_IDLE;
      buf_full    <= 1'b0;
      out_valid   <= 1'b0;
      head        <= '0;
      pos_count   <= '0;
      zero_flag   <= 1'b1;
      prev        <= '0;
      lane_load   <= 1'b0;
      merge_start <= 1'b0;
    end else begin
      lane_load   <= 1'b0;
      merge_start <= 1'b0;
      if (in_valid && in_ready) buf_full <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        E_IDLE: begin
          if (buf_full) begin
            w_bg     <= buf_bg;
            w_ms     <= buf_ms;
            w_eos    <= buf_eos;
            buf_full <= 1'b0;
            rcnt     <= 3'd0;
            state    <= E_READ;
          end
        end
        E_READ: begin
          // data for the slot issued last cycle arrives now
          if (rcnt != 3'd0) hv[2'(rcnt - 3'd1)] <= rd_zero ? score_t'(0) : rd_data;
          if (rcnt == 3'd4) begin
            lane_load <= 1'b1;
            state     <= E_LANE;
          end else begin
            rcnt <= rcnt + 3'd1;
          end
        end
        E_LANE: begin
          merge_start <= 1'b1;
          state       <= E_START;
        end
        E_START: state <= E_MERGE;
        E_MERGE: begin
          if (merge_done) state <= E_DONE;
        end
        E_DONE: begin
          if (fire) begin
            out_valid    <= 1'b1;
            prefix_score <= merge_acc;
            is_total     <= w_eos;
            if (w_eos) begin
              head      <= '0;
              pos_count <= '0;
              zero_flag <= 1'b1;
              prev      <= '0;
            end else begin
              head <= wr_addr;
              prev <= merge_acc;
              if (wr_addr == '0) zero_flag <= 1'b0;
              if (pos_count < CNT_BITS'(MAX_WIDTH)) pos_count <= pos_count + CNT_BITS'(1);
            end
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  mmfl_lane u_lane_bg (
    .clk    (clk),
    .load   (lane_load),
    .enable (1'b1),
    .hist   (prev),
    .score  (w_bg),
    .pen    (base_penalty),
    .term   (terms[0])
  );

  for (genvar g = 0; g < MAX_MOTIFS; g++) begin : g_lane
    mmfl_lane u_lane (
      .clk    (clk),
      .load   (lane_load),
      .enable (fit[g]),
      .hist   (hv[g]),
      .score  (w_ms[g]),
      .pen    (motif_penalties[16*g +: 16]),
      .term   (terms[g+1])
    );
  end

  mmfl_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .terms (terms),
    .done  (merge_done),
    .acc   (merge_acc)
  );

endmodule

// ===== hw/rtl/mmfl_checker.sv =====
// Port-level checker for the forward log-sum block, bound to the top level.
// Depends on motif_mixture_forward_logsum_macros.svh.
`include "motif_mixture_forward_logsum_macros.svh"

module mmfl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] prefix_score,
  input logic        is_total,
  input logic        psel,
  input logic        pready
);

  `MMFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(prefix_score) && $stable(is_total), "result changed while stalled")
  `MMFL_ASSERT_NEXT(a_buf_full, in_valid && in_ready, !in_ready, "input buffer did not fill on transaction")
  `MMFL_ASSERT_NOW(a_pready, psel, pready, "config port not ready")

endmodule

bind motif_mixture_forward_logsum mmfl_checker u_mmfl_checker (.*);
